// ===== rtl/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// clc_pkg
// Shared widths, fixed point constants, request codes and the control struct
// that the sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package clc_pkg;

  // unsigned Q1.16 values
  localparam int VAL_W  = 17;
  localparam int FRAC_W = 16;
  localparam int CODE_W = 16;
  localparam int STATE_W = 2;
  localparam int INDEX_W = 2;
  localparam int OP_W   = 2;

  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE_FIRST  = 2'd0,
    OP_WRITE_SECOND = 2'd1,
    OP_CHILD_PAIR   = 2'd2,
    OP_UNUSED       = 2'd3
  } op_t;

  typedef struct packed {
    logic clear;       // zero both branch sums
    logic term_valid;  // operands hold one matrix entry and one child element
    logic term_sel_b;  // term belongs to the second branch
    logic final_mul;   // multiply the two branch sums
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/clc_mac_unit.sv =====
// ----------------------------------------------------------------------------
// clc_mac_unit
// Shared multiplier with a product register and two branch accumulators.
// Forms truncated matrix-by-element terms, sums them per branch, then
// multiplies the two sums and saturates the result at 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module clc_mac_unit #(
  parameter int SUM_W = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire clc_pkg::mac_ctrl_t        ctrl,
  input  wire logic [clc_pkg::VAL_W-1:0] mat_data,
  input  wire logic [clc_pkg::VAL_W-1:0] vec_data,
  output logic                           pipe_busy,
  output logic [clc_pkg::VAL_W-1:0]      sat_result
);

  localparam int PROD_W = 2 * SUM_W;
  localparam int TERM_HI = 2 * clc_pkg::VAL_W - 1;
  localparam int HI_W = PROD_W - clc_pkg::FRAC_W;

  logic [SUM_W-1:0]  acc_a;
  logic [SUM_W-1:0]  acc_b;
  logic [PROD_W-1:0] prod;
  logic              prod_valid;
  logic              prod_sel_b;

  logic [SUM_W-1:0]  opnd_x;
  logic [SUM_W-1:0]  opnd_y;
  logic [SUM_W-1:0]  term;
  logic [HI_W-1:0]   prod_hi;

  assign opnd_x = ctrl.final_mul ? acc_a : SUM_W'(mat_data);
  assign opnd_y = ctrl.final_mul ? acc_b : SUM_W'(vec_data);

  // term is truncated by the fraction width before it is summed
  assign term = SUM_W'(prod[TERM_HI:clc_pkg::FRAC_W]);

  always_ff @(posedge clk) begin
    if (ctrl.term_valid || ctrl.final_mul) begin
      prod <= opnd_x * opnd_y;
    end
    prod_sel_b <= ctrl.term_sel_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc_a      <= '0;
      acc_b      <= '0;
    end else begin
      prod_valid <= ctrl.term_valid;
      if (ctrl.clear) begin
        acc_a <= '0;
        acc_b <= '0;
      end else if (prod_valid) begin
        if (prod_sel_b) begin
          acc_b <= acc_b + term;
        end else begin
          acc_a <= acc_a + term;
        end
      end
    end
  end

  assign pipe_busy = prod_valid;

  assign prod_hi = prod[PROD_W-1:clc_pkg::FRAC_W];
  assign sat_result = (prod_hi > HI_W'(clc_pkg::ONE_Q16)) ? clc_pkg::ONE_Q16
                                                           : prod_hi[clc_pkg::VAL_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/conditional_likelihood_combine.sv =====
// ----------------------------------------------------------------------------
// conditional_likelihood_combine
// Parent conditional likelihood of one character from two child vectors and
// two branch transition matrices, in unsigned Q1.16.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low.
//   op 0 and op 1 write one entry of the first or second matrix, op 2 writes
//   one child element pair and latches char_code; op 0 and op 1 never raise
//   busy. op 3 is taken and does nothing.
//   A pair with last_element set raises busy and starts the computation.
//   For each state i the shared multiplier runs 2*ALPHABET term products
//   (one matrix entry and one child element per cycle, read from registered
//   memories), then multiplies the two branch sums.
//   Results come out as ALPHABET strobes on valid, one per state in order,
//   with last_result on the final one; busy is already low in that cycle.
//   The receiver cannot stall: each result is valid for one cycle only.
//   Reset clears the sequencer and the held code; matrix and vector contents
//   are undefined until written and survive each computation.
// ----------------------------------------------------------------------------
`default_nettype none

module conditional_likelihood_combine #(
  parameter int ALPHABET = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [clc_pkg::OP_W-1:0]      op,
  input  wire logic [clc_pkg::INDEX_W-1:0]   row_index,
  input  wire logic [clc_pkg::INDEX_W-1:0]   col_index,
  input  wire logic [clc_pkg::VAL_W-1:0]     value_first,
  input  wire logic [clc_pkg::VAL_W-1:0]     value_second,
  input  wire logic [clc_pkg::CODE_W-1:0]    char_code,
  input  wire logic                          last_element,
  output logic                               valid,
  output logic [clc_pkg::CODE_W-1:0]         code_out,
  output logic [clc_pkg::STATE_W-1:0]        state_out,
  output logic [clc_pkg::VAL_W-1:0]          likelihood,
  output logic                               last_result
);

  localparam int IDX_W  = $clog2(ALPHABET);
  localparam int MAT_N  = ALPHABET * ALPHABET;
  localparam int MAT_AW = $clog2(MAT_N);
  localparam int SUM_W  = 2 * clc_pkg::VAL_W - clc_pkg::FRAC_W + $clog2(ALPHABET);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALPHABET - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  // storage
  logic [clc_pkg::VAL_W-1:0] mat_a [MAT_N];
  logic [clc_pkg::VAL_W-1:0] mat_b [MAT_N];
  logic [clc_pkg::VAL_W-1:0] vec_a [ALPHABET];
  logic [clc_pkg::VAL_W-1:0] vec_b [ALPHABET];
  logic [clc_pkg::VAL_W-1:0] mat_a_q, mat_b_q, vec_a_q, vec_b_q;
  logic [clc_pkg::CODE_W-1:0] held_code;

  // sequencer registers
  logic [IDX_W-1:0]  state_idx;
  logic [IDX_W-1:0]  col_cnt;
  logic              half_b;
  logic [MAT_AW-1:0] row_base;
  logic              rd_valid;
  logic              rd_sel_b;

  logic                  accept;
  logic                  launch;
  logic                  row_ok, col_ok;
  logic [MAT_AW-1:0]     wr_addr;
  logic [MAT_AW-1:0]     rd_addr;
  logic                  issue_end;
  logic                  pipe_busy;
  logic [clc_pkg::VAL_W-1:0] sat_result;
  clc_pkg::mac_ctrl_t    mac_ctrl;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign launch = accept && (op == clc_pkg::OP_CHILD_PAIR) && last_element;

  assign row_ok  = int'(row_index) < ALPHABET;
  assign col_ok  = int'(col_index) < ALPHABET;
  assign wr_addr = MAT_AW'(int'(row_index) * ALPHABET + int'(col_index));
  assign rd_addr = row_base + MAT_AW'(col_cnt);

  assign issue_end = half_b && (col_cnt == IDX_LAST);

  // memories: one write port from requests, one registered read port each
  always_ff @(posedge clk) begin
    if (accept && row_ok && col_ok && (op == clc_pkg::OP_WRITE_FIRST)) begin
      mat_a[wr_addr] <= value_first;
    end
    if (accept && row_ok && col_ok && (op == clc_pkg::OP_WRITE_SECOND)) begin
      mat_b[wr_addr] <= value_first;
    end
    if (accept && col_ok && (op == clc_pkg::OP_CHILD_PAIR)) begin
      vec_a[IDX_W'(col_index)] <= value_first;
      vec_b[IDX_W'(col_index)] <= value_second;
    end
    mat_a_q <= mat_a[rd_addr];
    mat_b_q <= mat_b[rd_addr];
    vec_a_q <= vec_a[col_cnt];
    vec_b_q <= vec_b[col_cnt];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (launch) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !pipe_busy) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = (state_idx == IDX_LAST) ? ST_IDLE : ST_ISSUE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      state_idx <= '0;
      col_cnt   <= '0;
      half_b    <= 1'b0;
      row_base  <= '0;
      rd_valid  <= 1'b0;
      held_code <= '0;
      valid     <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_ISSUE);
      valid    <= (state == ST_EMIT);
      if (accept && (op == clc_pkg::OP_CHILD_PAIR)) begin
        held_code <= char_code;
      end
      if (launch) begin
        state_idx <= '0;
        col_cnt   <= '0;
        half_b    <= 1'b0;
        row_base  <= '0;
      end else if (state == ST_ISSUE) begin
        // first branch over all columns, then the second
        if (col_cnt == IDX_LAST) begin
          col_cnt <= '0;
          half_b  <= !half_b;
        end else begin
          col_cnt <= col_cnt + 1'b1;
        end
      end else if (state == ST_EMIT) begin
        state_idx <= state_idx + 1'b1;
        row_base  <= row_base + MAT_AW'(ALPHABET);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sel_b <= half_b;
    if (state == ST_EMIT) begin
      code_out    <= held_code;
      state_out   <= clc_pkg::STATE_W'(state_idx);
      likelihood  <= sat_result;
      last_result <= (state_idx == IDX_LAST);
    end
  end

  always_comb begin
    mac_ctrl.clear      = launch || (state == ST_EMIT);
    mac_ctrl.term_valid = rd_valid;
    mac_ctrl.term_sel_b = rd_sel_b;
    mac_ctrl.final_mul  = (state == ST_FINAL);
  end

  clc_mac_unit #(
    .SUM_W(SUM_W)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .mat_data   (rd_sel_b ? mat_b_q : mat_a_q),
    .vec_data   (rd_sel_b ? vec_b_q : vec_a_q),
    .pipe_busy  (pipe_busy),
    .sat_result (sat_result)
  );

`ifndef NO_ASSERTIONS
  // the final product must not collide with a term still in flight
  a_final_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL) |-> (!rd_valid && !pipe_busy))
    else $error("final multiply overlaps term pipeline");

  // a launch request always makes the block busy
  a_launch_busy: assert property (@(posedge clk) disable iff (rst)
    launch |=> busy)
    else $error("launch did not raise busy");

  // the last result leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && last_result) |-> !busy)
    else $error("busy after last result");

  // results come only out of a computation
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result without computation");
`endif

endmodule

`default_nettype wire
